// ----- sv/dpp_pkg.sv -----
// Shared types, codes and the color classifier of the dual plane pixel plotter.
`default_nettype none
package dpp_pkg;

  // Byte address carried between front and back; covers the largest panel.
  localparam int CMD_ADDR_W = 15;

  // Input action codes.
  localparam logic [1:0] ACT_PLOT = 2'd0;
  localparam logic [1:0] ACT_FILL = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // Rotation register codes, quarter turns.
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  localparam logic [15:0] COL_WHITE = 16'hFFFF;
  localparam logic [15:0] COL_BLACK = 16'h0000;
  localparam logic [15:0] COL_RED   = 16'hF800;
  localparam logic [15:0] MASK_R    = 16'hF100;
  localparam logic [15:0] MASK_G    = 16'h07E0;
  localparam logic [15:0] MASK_B    = 16'h001F;
  localparam logic [15:0] RED_LIMIT = 16'(16'hF100 / 2);
  localparam logic [15:0] DARK_SUM  = 16'(3 * 255 / 2);

  typedef enum logic [1:0] {
    OP_PLOT,
    OP_FILL,
    OP_READ
  } op_t;

  typedef enum logic [1:0] {
    SH_WHITE,
    SH_BLACK,
    SH_RED
  } shade_t;

  typedef struct packed {
    op_t                   op;
    logic [CMD_ADDR_W-1:0] addr;
    logic [7:0]            mask;
    shade_t                shade;
    logic                  beyond;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PLOT_WR,
    ST_READ
  } back_state_t;

  function automatic shade_t classify(input logic [15:0] c);
    logic [15:0] sum;
    sum = ((c & MASK_R) >> 11) + ((c & MASK_G) >> 5) + (c & MASK_B);
    if (c == COL_WHITE) return SH_WHITE;
    if (c == COL_BLACK) return SH_BLACK;
    if (c == COL_RED) return SH_RED;
    if ((c & MASK_R) > RED_LIMIT) return SH_RED;
    if (sum < DARK_SUM) return SH_BLACK;
    return SH_WHITE;
  endfunction

endpackage
`default_nettype wire

// ----- sv/dpp_ram.sv -----
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module dpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4736
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/dpp_front.sv -----
// Front end: accepts words, bounds checks, rotates, classifies, forms byte commands.
`default_nettype none
module dpp_front import dpp_pkg::*; #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 296
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [1:0]         rotation,
  input  wire logic               accept,
  input  wire logic [1:0]         action,
  input  wire logic signed [10:0] pos_x,
  input  wire logic signed [10:0] pos_y,
  input  wire logic [15:0]        color,
  input  wire logic [12:0]        byte_index,
  output logic                    busy,
  output logic                    q_push,
  output cmd_t                    q_wdata,
  input  wire logic               q_full
);

  localparam int STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT) / 8;
  localparam logic [10:0] LW0 = 11'(PANEL_WIDTH);
  localparam logic [10:0] LH0 = 11'(PANEL_HEIGHT);
  localparam logic [9:0]  WM1 = 10'(PANEL_WIDTH - 1);
  localparam logic [9:0]  HM1 = 10'(PANEL_HEIGHT - 1);

  // stage 0: bounds and rotation
  logic [10:0] lw, lh;
  logic        in_bounds, keep0;
  logic [9:0]  xu, yu, px, py;
  op_t         op0;

  always_comb begin
    lw = rotation[0] ? LH0 : LW0;
    lh = rotation[0] ? LW0 : LH0;
    in_bounds = !pos_x[10] && !pos_y[10] &&
                ($unsigned(pos_x) < lw) && ($unsigned(pos_y) < lh);
    xu = pos_x[9:0];
    yu = pos_y[9:0];
    case (rotation)
      ROT_90: begin
        px = WM1 - yu;
        py = xu;
      end
      ROT_180: begin
        px = WM1 - xu;
        py = HM1 - yu;
      end
      ROT_270: begin
        px = yu;
        py = HM1 - xu;
      end
      default: begin
        px = xu;
        py = yu;
      end
    endcase
    case (action)
      ACT_PLOT: begin
        op0   = OP_PLOT;
        keep0 = in_bounds;
      end
      ACT_FILL: begin
        op0   = OP_FILL;
        keep0 = 1'b1;
      end
      ACT_READ: begin
        op0   = OP_READ;
        keep0 = 1'b1;
      end
      default: begin
        op0   = OP_PLOT;
        keep0 = 1'b0;
      end
    endcase
  end

  // stage 1 registers
  logic        s1_valid;
  op_t         s1_op;
  logic [9:0]  s1_px, s1_py;
  shade_t      s1_shade;
  logic [12:0] s1_bidx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || !q_full) begin
      s1_valid <= accept && keep0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op    <= op0;
      s1_px    <= px;
      s1_py    <= py;
      s1_shade <= classify(color);
      s1_bidx  <= byte_index;
    end
  end

  // stage 1: byte index and mask
  logic [19:0] row_off, idx;
  logic        keep1;

  always_comb begin
    row_off = 20'(s1_py) * 20'(PANEL_WIDTH);
    idx     = 20'(s1_px >> 3) + (row_off >> 3);
    keep1   = (s1_op != OP_PLOT) || (idx < 20'(STORE_BYTES));
    q_wdata.op     = s1_op;
    q_wdata.addr   = (s1_op == OP_READ) ? CMD_ADDR_W'(s1_bidx) : idx[CMD_ADDR_W-1:0];
    q_wdata.mask   = 8'h80 >> s1_px[2:0];
    q_wdata.shade  = s1_shade;
    q_wdata.beyond = {3'b000, s1_bidx} >= 16'(STORE_BYTES);
  end

  assign q_push = s1_valid && !q_full && keep1;
  assign busy   = s1_valid && q_full;

endmodule
`default_nettype wire

// ----- sv/dpp_queue.sv -----
// Short command queue between front and back.
`default_nettype none
module dpp_queue import dpp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t wdata,
  output logic      full,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty
);

  localparam int AW = $clog2(DEPTH);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count;

  assign full  = count == (AW + 1)'(DEPTH);
  assign empty = count == '0;
  assign head  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      count <= count + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ----- sv/dpp_back.sv -----
// Back end: plane memories, read-modify-write of plots, fill/clear sweep, read results.
`default_nettype none
module dpp_back import dpp_pkg::*; #(
  parameter int STORE_BYTES = 4736
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t head,
  input  wire logic q_empty,
  output logic      q_pop,
  output logic      clearing,
  output logic      empty,
  input  wire logic pop,
  output logic [7:0] black_out,
  output logic [7:0] red_out
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam logic [AW-1:0] LAST = AW'(STORE_BYTES - 1);

  back_state_t   state, state_next;
  cmd_t          cur;
  logic [AW-1:0] cnt;
  logic [7:0]    sweep_b, sweep_r;
  logic          out_valid;

  logic          we, out_load;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata_b, wdata_r, rdata_b, rdata_r;

  dpp_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_black (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata_b), .raddr(raddr), .rdata(rdata_b)
  );

  dpp_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_red (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata_r), .raddr(raddr), .rdata(rdata_r)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_SWEEP: begin
        if (cnt == LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (!q_empty) begin
          case (head.op)
            OP_PLOT: state_next = ST_PLOT_WR;
            OP_FILL: state_next = ST_SWEEP;
            OP_READ: state_next = ST_READ;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_PLOT_WR: state_next = ST_IDLE;
      ST_READ: begin
        if (!out_valid || pop) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    we       = 1'b0;
    waddr    = cur.addr[AW-1:0];
    raddr    = cur.addr[AW-1:0];
    wdata_b  = sweep_b;
    wdata_r  = sweep_r;
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_SWEEP: begin
        we    = 1'b1;
        waddr = cnt;
      end
      ST_IDLE: begin
        q_pop = !q_empty;
        raddr = head.addr[AW-1:0];
      end
      ST_PLOT_WR: begin
        // clear to white, then mark the classified shade
        we      = 1'b1;
        wdata_b = (rdata_b & ~cur.mask) | ((cur.shade == SH_BLACK) ? cur.mask : 8'h00);
        wdata_r = (rdata_r | cur.mask) & ~((cur.shade == SH_RED) ? cur.mask : 8'h00);
      end
      ST_READ: begin
        out_load = !out_valid || pop;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      cnt       <= '0;
      sweep_b   <= 8'h00;
      sweep_r   <= 8'hFF;
      clearing  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_SWEEP) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) clearing <= 1'b0;
      end
      if (q_pop && head.op == OP_FILL) begin
        cnt     <= '0;
        sweep_b <= (head.shade == SH_BLACK) ? 8'hFF : 8'h00;
        sweep_r <= (head.shade == SH_RED) ? 8'h00 : 8'hFF;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= head;
    end
    if (out_load) begin
      black_out <= cur.beyond ? 8'hFF : ~rdata_b;
      red_out   <= cur.beyond ? 8'hFF : ~rdata_r;
    end
  end

  assign empty = !out_valid;

endmodule
`default_nettype wire

// ----- sv/dual_plane_pixel_plotter.sv -----
// Top level of the dual plane pixel plotter: front end, command queue, back end.
// Read path: a read word accepted with the queue empty passes the stage 1
//   register, the queue write, the RAM read and the output register.
// Throughput: a plot or read takes two back end states (RAM read, then write or
//   result load; a read waits on an unpopped result); a fill sweeps one byte per cycle.
// Reset: synchronous, active high; then both planes are cleared to white by the
//   same sweep, over W*H/8 bytes (4736 at the defaults), while full stays high.
`default_nettype none
module dual_plane_pixel_plotter import dpp_pkg::*; #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 296
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_wdata,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         action,
  input  wire logic signed [10:0] pos_x,
  input  wire logic signed [10:0] pos_y,
  input  wire logic [15:0]        color,
  input  wire logic [12:0]        byte_index,
  output logic                    empty,
  input  wire logic               pop,
  output logic [7:0]              black_out,
  output logic [7:0]              red_out
);

  localparam int STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT) / 8;

  // rotation register; the user must write it only while the block is idle, the block itself has no guard for this
  logic [1:0] rotation;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation <= ROT_0;
    end else if (cfg_we) begin
      rotation <= cfg_wdata;
    end
  end

  logic front_busy, clearing, accept;
  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_wdata, q_head;

  // no word is taken while the reset sweep is clearing the planes
  assign full   = front_busy || clearing;
  assign accept = push && !full;

  // front: bounds check, rotation and color class; drops off-panel plots
  dpp_front #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .rotation  (rotation),
    .accept    (accept),
    .action    (action),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .color     (color),
    .byte_index(byte_index),
    .busy      (front_busy),
    .q_push    (q_push),
    .q_wdata   (q_wdata),
    .q_full    (q_full)
  );

  // decoupling queue; keeps words in order
  dpp_queue #(.DEPTH(4)) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .head (q_head),
    .empty(q_empty)
  );

  // back: owns the plane RAMs and the result register
  dpp_back #(.STORE_BYTES(STORE_BYTES)) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .clearing (clearing),
    .empty    (empty),
    .pop      (pop),
    .black_out(black_out),
    .red_out  (red_out)
  );

endmodule
`default_nettype wire

// ----- sv/dpp_checker.sv -----
// Port level checker for the dual plane pixel plotter, bound to the top level.
`default_nettype none
module dpp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] black_out,
  input wire logic [7:0] red_out
);

  // reset starts the clearing sweep with no result pending
  a_reset_state: assert property (@(posedge clk) rst |=> (full && empty))
    else $error("full/empty wrong after reset");

  // the clearing sweep keeps full high after reset falls
  a_clear_holds: assert property (@(posedge clk) $fell(rst) |=> full)
    else $error("accepting words during clear sweep");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("result dropped without pop");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> ($stable(black_out) && $stable(red_out)))
    else $error("stalled result changed");

endmodule

bind dual_plane_pixel_plotter dpp_checker u_dpp_checker (
  .clk      (clk),
  .rst      (rst),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .black_out(black_out),
  .red_out  (red_out)
);
`default_nettype wire

// ----- test/plane_checker.sv -----
// Checker for the plotter: tracks both bit planes and compares every read word.
module plane_checker import dpp_pkg::*; #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 296
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  input  logic               push,
  input  logic               full,
  input  logic [1:0]         action,
  input  logic signed [10:0] pos_x,
  input  logic signed [10:0] pos_y,
  input  logic [15:0]        color,
  input  logic [12:0]        byte_index,
  input  logic               empty,
  input  logic               pop,
  input  logic [7:0]         black_out,
  input  logic [7:0]         red_out,
  output int                 fail_count,
  output int                 words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_BYTES = PANEL_WIDTH * PANEL_HEIGHT / 8;

  typedef struct packed {
    logic [7:0] black;
    logic [7:0] red;
  } read_word_t;

  logic [7:0] black_plane [STORE_BYTES];
  logic [7:0] red_plane [STORE_BYTES];
  logic [1:0] rotation;
  read_word_t read_words_due [$];
  read_word_t oldest;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // only the top bit of the red mask decides red; dark sum is against 382
  function automatic shade_t color_shade(input logic [15:0] c);
    int red_bits;
    int level;
    red_bits = int'(c & MASK_R);
    level = (red_bits >> 11) + (int'(c & MASK_G) >> 5) + int'(c & MASK_B);
    if (c == COL_WHITE) return SH_WHITE;
    if (c == COL_BLACK) return SH_BLACK;
    if (c == COL_RED) return SH_RED;
    if (red_bits > int'(MASK_R) / 2) return SH_RED;
    if (level < 3 * 255 / 2) return SH_BLACK;
    return SH_WHITE;
  endfunction

  function automatic void plot_pixel(input logic signed [10:0] lx, input logic signed [10:0] ly,
                                     input logic [15:0] c);
    int x;
    int y;
    int t;
    int lw;
    int lh;
    int idx;
    logic [7:0] pix;
    shade_t s;
    lw = rotation[0] ? PANEL_HEIGHT : PANEL_WIDTH;
    lh = rotation[0] ? PANEL_WIDTH : PANEL_HEIGHT;
    x = lx;
    y = ly;
    if (x < 0 || x >= lw || y < 0 || y >= lh) return;
    case (rotation)
      ROT_90: begin
        t = x;
        x = PANEL_WIDTH - 1 - y;
        y = t;
      end
      ROT_180: begin
        x = PANEL_WIDTH - 1 - x;
        y = PANEL_HEIGHT - 1 - y;
      end
      ROT_270: begin
        t = x;
        x = y;
        y = PANEL_HEIGHT - 1 - t;
      end
      default: ;
    endcase
    idx = x / 8 + (y * PANEL_WIDTH) / 8;
    if (idx >= STORE_BYTES) return;
    pix = 8'h80 >> (x % 8);
    s = color_shade(c);
    // pixel goes white first, then takes its shade
    black_plane[idx] = black_plane[idx] & ~pix;
    red_plane[idx] = red_plane[idx] | pix;
    if (s == SH_BLACK) black_plane[idx] = black_plane[idx] | pix;
    else if (s == SH_RED) red_plane[idx] = red_plane[idx] & ~pix;
  endfunction

  function automatic void fill_planes(input logic [15:0] c);
    shade_t s;
    s = color_shade(c);
    for (int i = 0; i < STORE_BYTES; i++) begin
      black_plane[i] = (s == SH_BLACK) ? 8'hFF : 8'h00;
      red_plane[i] = (s == SH_RED) ? 8'h00 : 8'hFF;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE_BYTES; i++) begin
        black_plane[i] = 8'h00;
        red_plane[i] = 8'hFF;
      end
      rotation = ROT_0;
      read_words_due.delete();
    end else begin
      if (pop && !empty) begin
        if (read_words_due.size() == 0) begin
          report_mismatch($sformatf("read word with none due (black %02h red %02h)",
                                    black_out, red_out));
        end else begin
          oldest = read_words_due.pop_front();
          if (black_out !== oldest.black)
            report_mismatch($sformatf("black_out %02h, want %02h", black_out, oldest.black));
          if (red_out !== oldest.red)
            report_mismatch($sformatf("red_out %02h, want %02h", red_out, oldest.red));
        end
      end
      if (cfg_we) rotation = cfg_wdata;
      if (push && !full) begin
        case (action)
          ACT_PLOT: plot_pixel(pos_x, pos_y, color);
          ACT_FILL: fill_planes(color);
          ACT_READ: begin
            if (byte_index < STORE_BYTES)
              read_words_due.push_back('{~black_plane[byte_index], ~red_plane[byte_index]});
            else
              read_words_due.push_back('{8'hFF, 8'hFF});
          end
          default: ;
        endcase
      end
    end
    words_due = read_words_due.size();
  end

endmodule

// ----- test/dual_plane_pixel_plotter_test.sv -----
// Testbench top for the dual plane pixel plotter: reset, stimulus and verdict.
module dual_plane_pixel_plotter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dpp_pkg::*;

  localparam int PANEL_W = 128;
  localparam int PANEL_H = 296;
  localparam int STORE_BYTES = PANEL_W * PANEL_H / 8;
  localparam int ROW_BYTES = PANEL_W / 8;

  // Action code 3 has no meaning; the block must swallow it.
  localparam logic [1:0] ACT_NONE = 2'd3;

  // Random part: eight phases, each run under the rotation chosen for it.
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 170;
  // Every fill sweeps the whole store (4736 bytes), so keep them few.
  localparam int FILL_BUDGET = 12;
  // Receiver stalls for a long stretch in this phase so the queue backs up.
  localparam int HOLD_PHASE = 2;
  localparam int HOLD_CYCLES = 400;
  // In this phase neither side idles.
  localparam int CALM_PHASE = 4;
  // Pause after the last word, well past the read latency.
  localparam int SETTLE_CYCLES = 16;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [1:0]         cfg_wdata;
  logic               push;
  logic               full;
  logic [1:0]         action;
  logic signed [10:0] pos_x;
  logic signed [10:0] pos_y;
  logic [15:0]        color;
  logic [12:0]        byte_index;
  logic               empty;
  logic               pop;
  logic [7:0]         black_out;
  logic [7:0]         red_out;

  int fail_count;
  int words_due;
  int phase_no;

  dual_plane_pixel_plotter #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .full      (full),
    .action    (action),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .color     (color),
    .byte_index(byte_index),
    .empty     (empty),
    .pop       (pop),
    .black_out (black_out),
    .red_out   (red_out)
  );

  plane_checker #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H)
  ) i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .full      (full),
    .action    (action),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .color     (color),
    .byte_index(byte_index),
    .empty     (empty),
    .pop       (pop),
    .black_out (black_out),
    .red_out   (red_out),
    .fail_count(fail_count),
    .words_due (words_due)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop, about ten times the slowest expected run.
  initial begin
    #8_000_000;
    $display("dual_plane_pixel_plotter regression: fail");
    $finish;
  end

  // Colors: white only comes from its exact code, so weight the fixed codes;
  // random codes split between red (top bit set) and black.
  function automatic logic [15:0] pick_color();
    case ($urandom_range(0, 7))
      0, 1: return COL_WHITE;
      2: return COL_BLACK;
      3: return COL_RED;
      default: return 16'($urandom);
    endcase
  endfunction

  // Reads land on the outer two byte columns of the top and bottom 16 rows:
  // that is where the corner plots end up under every rotation.
  function automatic int corner_byte();
    int row;
    int col;
    row = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 15)
                                      : PANEL_H - 1 - $urandom_range(0, 15);
    col = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 1)
                                      : ROW_BYTES - 1 - $urandom_range(0, 1);
    return row * ROW_BYTES + col;
  endfunction

  // One word on the input queue. Random gaps before it (none in the calm
  // phase); push stays high back to back when no gap is drawn.
  task automatic send_word(input logic [1:0] act, input int x, input int y,
                           input logic [15:0] c, input int bi);
    @(negedge clk);
    while (phase_no != CALM_PHASE && $urandom_range(0, 99) < 25) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push       <= 1'b1;
    action     <= act;
    pos_x      <= x[10:0];
    pos_y      <= y[10:0];
    color      <= c;
    byte_index <= bi[12:0];
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Plots and fills return nothing, so a trailing read marks the point where
  // all earlier work has finished. Once its word is back and a short pause has
  // passed, the block is idle and the rotation can change.
  task automatic drain_and_rotate(input logic [1:0] r);
    send_word(ACT_READ, 0, 0, COL_BLACK, 0);
    @(negedge clk);
    push <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: pops about 75% of cycles, always in the calm phase, and once
  // stops for a long stretch while the sender keeps going.
  initial begin : receiver
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_no == HOLD_PHASE && !held) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (phase_no == CALM_PHASE) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(0, 99) >= 25);
      end
    end
  end

  initial begin : stimulus
    logic [1:0] plan [PHASES];
    logic [1:0] rot_now;
    int lw;
    int lh;
    int k;
    int x;
    int y;
    int fills_left;

    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_wdata  = ROT_0;
    push       = 1'b0;
    action     = ACT_PLOT;
    pos_x      = '0;
    pos_y      = '0;
    color      = COL_BLACK;
    byte_index = '0;
    phase_no   = 0;

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    // rotation written once straight after reset; the clearing sweep runs
    // meanwhile and holds full high, which send_word simply waits out
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ROT_0;
    @(negedge clk);
    cfg_we <= 1'b0;

    // Directed part, unrotated panel.
    // fresh store reads white; last byte, first byte past it, top index
    send_word(ACT_READ, 0, 0, COL_BLACK, 0);
    send_word(ACT_READ, 0, 0, COL_BLACK, STORE_BYTES - 1);
    send_word(ACT_READ, 0, 0, COL_BLACK, STORE_BYTES);
    send_word(ACT_READ, -1, -1, COL_WHITE, 8191);
    // corners, fixed codes, near-boundary classifier codes, then white over black
    send_word(ACT_PLOT, 0, 0, COL_BLACK, 8191);
    send_word(ACT_PLOT, PANEL_W - 1, PANEL_H - 1, COL_RED, 0);
    send_word(ACT_PLOT, 1, 0, 16'h7FFF, 0);
    send_word(ACT_PLOT, 2, 0, 16'h8000, 0);
    send_word(ACT_PLOT, 3, 0, 16'h7880, 0);
    send_word(ACT_PLOT, 0, 0, COL_WHITE, 0);
    // off the panel: one past each edge, negatives, field extremes
    send_word(ACT_PLOT, PANEL_W, 0, COL_BLACK, 0);
    send_word(ACT_PLOT, 0, PANEL_H, COL_BLACK, 0);
    send_word(ACT_PLOT, -1, 5, COL_BLACK, 0);
    send_word(ACT_PLOT, 5, -1024, COL_BLACK, 0);
    send_word(ACT_PLOT, 1023, 1023, COL_BLACK, 0);
    send_word(ACT_NONE, 0, 0, COL_BLACK, 0);
    send_word(ACT_READ, 0, 0, COL_BLACK, 0);
    send_word(ACT_READ, 0, 0, COL_BLACK, STORE_BYTES - 1);
    // fills in all three shades, each checked by a read
    send_word(ACT_FILL, 0, 0, 16'h1234, 0);
    send_word(ACT_READ, 0, 0, COL_BLACK, 100);
    send_word(ACT_FILL, 0, 0, COL_RED, 0);
    send_word(ACT_READ, 0, 0, COL_BLACK, 2000);
    send_word(ACT_FILL, 0, 0, COL_WHITE, 0);
    send_word(ACT_READ, 0, 0, COL_BLACK, 0);

    // Random part: every rotation in turn, then four random ones.
    plan[0] = ROT_90;
    plan[1] = ROT_180;
    plan[2] = ROT_270;
    plan[3] = ROT_0;
    for (int p = 4; p < PHASES; p++) plan[p] = 2'($urandom_range(0, 3));
    fills_left = FILL_BUDGET;

    for (int p = 1; p <= PHASES; p++) begin
      rot_now = plan[p - 1];
      drain_and_rotate(rot_now);
      phase_no = p;
      lw = rot_now[0] ? PANEL_H : PANEL_W;
      lh = rot_now[0] ? PANEL_W : PANEL_H;
      repeat (WORDS_PER_PHASE) begin
        k = $urandom_range(0, 99);
        if (k < 50) begin
          // 16x16 window at the logical origin or the far corner
          if ($urandom_range(0, 1) == 1) begin
            x = $urandom_range(0, 15);
            y = $urandom_range(0, 15);
          end else begin
            x = lw - 1 - int'($urandom_range(0, 15));
            y = lh - 1 - int'($urandom_range(0, 15));
          end
          send_word(ACT_PLOT, x, y, pick_color(), $urandom_range(0, 8191));
        end else if (k < 58) begin
          send_word(ACT_PLOT, $urandom_range(0, lw - 1), $urandom_range(0, lh - 1),
                    pick_color(), $urandom_range(0, 8191));
        end else if (k < 64) begin
          // straddle the rotated bounds, in and out
          x = ($urandom_range(0, 1) == 1) ? lw - 2 + int'($urandom_range(0, 3))
                                          : int'($urandom_range(0, 3)) - 2;
          y = ($urandom_range(0, 1) == 1) ? lh - 2 + int'($urandom_range(0, 3))
                                          : int'($urandom_range(0, 3)) - 2;
          send_word(ACT_PLOT, x, y, pick_color(), $urandom_range(0, 8191));
        end else if (k < 70) begin
          // whole 11-bit range, mostly dropped
          send_word(ACT_PLOT, $urandom_range(0, 2047), $urandom_range(0, 2047),
                    pick_color(), $urandom_range(0, 8191));
        end else if (k < 85) begin
          send_word(ACT_READ, $urandom_range(0, 2047), $urandom_range(0, 2047),
                    16'($urandom), corner_byte());
        end else if (k < 92) begin
          send_word(ACT_READ, $urandom_range(0, 2047), $urandom_range(0, 2047),
                    16'($urandom), $urandom_range(0, 8191));
        end else if (k < 96) begin
          send_word(ACT_READ, 0, 0, COL_BLACK, $urandom_range(0, STORE_BYTES - 1));
        end else if (k < 98) begin
          send_word(ACT_NONE, $urandom_range(0, 2047), $urandom_range(0, 2047),
                    16'($urandom), $urandom_range(0, 8191));
        end else if (fills_left > 0) begin
          fills_left--;
          send_word(ACT_FILL, $urandom_range(0, 2047), $urandom_range(0, 2047),
                    pick_color(), $urandom_range(0, 8191));
        end else begin
          send_word(ACT_READ, 0, 0, COL_BLACK, corner_byte());
        end
      end
    end

    // Wind down: no more words in, every expected read word out, then a pause.
    @(negedge clk);
    push <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("dual_plane_pixel_plotter regression: pass");
    end else begin
      $display("dual_plane_pixel_plotter regression: fail");
    end
    $finish;
  end

endmodule
